// File: rtl/cda_pkg.sv
// ----------------------------------------------------------------------------
// cda_pkg
// Shared types, constants and constant-divide helpers for Gregorian date
// arithmetic.
// ----------------------------------------------------------------------------
package cda_pkg;

   localparam int YEAR_W   = 14;
   localparam int MONTH_W  = 4;
   localparam int DAY_W    = 5;
   localparam int OFFSET_W = 17;
   localparam int DIFF_W   = 23;
   localparam int SERIAL_W = 23;

   localparam int YEAR_BIAS  = 400;
   localparam int DAYS_400Y  = 146097;
   localparam int DAYS_100Y  = 36524;
   localparam int DAYS_4Y    = 1461;
   localparam int DAYS_1Y    = 365;
   localparam int DIFF_LIMIT = 4194303;
   localparam int YEAR_MIN   = 1;
   localparam int YEAR_MAX   = 9999;

   typedef enum logic [1:0] {
      FUNC_ADD  = 2'd0,
      FUNC_SUB  = 2'd1,
      FUNC_DIFF = 2'd2,
      FUNC_CMP  = 2'd3
   } func_type;

   // Reciprocal constants, exact for the operand ranges used below
   localparam int      K25   = 18;
   localparam longint  M25   = ((64'd1 << K25) + 64'd24) / 64'd25;
   localparam int      K400Y = 41;
   localparam longint  M400Y = ((64'd1 << K400Y) + 64'(DAYS_400Y) - 64'd1) / 64'(DAYS_400Y);
   localparam int      K4Y   = 27;
   localparam longint  M4Y   = ((64'd1 << K4Y) + 64'(DAYS_4Y) - 64'd1) / 64'(DAYS_4Y);

   // Quotient by 25 of a value below 6400, the largest whose quotient fits the 8-bit result
   function automatic logic [7:0] div25(input logic [12:0] x);
      logic [31:0] p;
      p = 32'(x) * 32'(M25);
      return p[K25+7:K25];
   endfunction

   // Number of whole 400-year cycles in a serial day count
   function automatic logic [5:0] div_400y(input logic [SERIAL_W-1:0] s);
      logic [63:0] p;
      p = 64'(s) * 64'(M400Y);
      return p[K400Y+5:K400Y];
   endfunction

   // Number of whole 4-year cycles in a remainder below 46752, so that the count fits five bits
   function automatic logic [4:0] div_4y(input logic [15:0] r);
      logic [63:0] p;
      p = 64'(r) * 64'(M4Y);
      return p[K4Y+4:K4Y];
   endfunction

   // Days before the first of a month in a common year
   function automatic logic [8:0] month_start(input logic [MONTH_W-1:0] m);
      case (m)
         4'd1:    return 9'd0;
         4'd2:    return 9'd31;
         4'd3:    return 9'd59;
         4'd4:    return 9'd90;
         4'd5:    return 9'd120;
         4'd6:    return 9'd151;
         4'd7:    return 9'd181;
         4'd8:    return 9'd212;
         4'd9:    return 9'd243;
         4'd10:   return 9'd273;
         4'd11:   return 9'd304;
         4'd12:   return 9'd334;
         default: return 9'd0;
      endcase
   endfunction

endpackage

// File: rtl/calendar_date_arithmetic.sv
// Path: an accepted req_ item is registered in stages 0 through 8, the last of which drives rsp_valid.
// Throughput: one item per cycle; a stall on rsp_ready freezes the whole pipeline.
// Reset: synchronous, active high; clears every stage valid bit and rsp_valid.
// ----------------------------------------------------------------------------
// calendar_date_arithmetic
// Gregorian date shift, day difference and order compare, as a nine-stage
// pipeline over serial day counts.
// ----------------------------------------------------------------------------
module calendar_date_arithmetic (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic [1:0]                     req_func,
   input  logic [cda_pkg::YEAR_W-1:0]     req_year,
   input  logic [cda_pkg::MONTH_W-1:0]    req_month,
   input  logic [cda_pkg::DAY_W-1:0]      req_day,
   input  logic signed [cda_pkg::OFFSET_W-1:0] req_offset_days,
   input  logic [cda_pkg::YEAR_W-1:0]     req_other_year,
   input  logic [cda_pkg::MONTH_W-1:0]    req_other_month,
   input  logic [cda_pkg::DAY_W-1:0]      req_other_day,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic [cda_pkg::YEAR_W-1:0]     rsp_result_year,
   output logic [cda_pkg::MONTH_W-1:0]    rsp_result_month,
   output logic [cda_pkg::DAY_W-1:0]      rsp_result_day,
   output logic signed [cda_pkg::DIFF_W-1:0] rsp_day_difference,
   output logic                           rsp_is_greater,
   output logic                           rsp_is_equal,
   output logic                           rsp_is_less,
   output logic                           rsp_overflow
);
   import cda_pkg::*;

   localparam int STAGES = 8;

   // One enable for every stage: advance whenever the output slot is free
   logic advance;
   logic [STAGES-1:0] valid_ff;
   logic              rsp_valid_ff;

   assign advance   = !rsp_valid_ff || rsp_ready;
   assign req_ready = advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff     <= {valid_ff[STAGES-2:0], req_valid};
         rsp_valid_ff <= valid_ff[STAGES-1];
      end
   end

   // ---------------- stage 0: capture the item ----------------
   logic [1:0]                s0_func_ff;
   logic [YEAR_W-1:0]         s0_y_ff, s0_oy_ff;
   logic [MONTH_W-1:0]        s0_m_ff, s0_om_ff;
   logic [DAY_W-1:0]          s0_d_ff, s0_od_ff;
   logic [OFFSET_W-1:0]       s0_off_ff;

   always_ff @(posedge clock) begin
      if (advance) begin
         s0_func_ff <= req_func;
         s0_y_ff    <= req_year;
         s0_m_ff    <= req_month;
         s0_d_ff    <= req_day;
         s0_off_ff  <= req_offset_days;
         s0_oy_ff   <= req_other_year;
         s0_om_ff   <= req_other_month;
         s0_od_ff   <= req_other_day;
      end
   end

   // ---------------- stage 1: year quotients for both dates ----------------
   // Index 0 is the first date, index 1 the second.
   logic [14:0]        s1_y1_in [2];
   logic [1:0]         s1_yb_lo_in [2];
   logic [12:0]        s1_yb4_in [2];
   logic [7:0]         s1_q100_in [2], s1_q400_in [2], s1_qb_in [2];
   logic [MONTH_W-1:0] s1_mc_in [2];
   logic               s1_gt_in, s1_eq_in;

   logic [14:0]        s1_y1_ff [2];
   logic [1:0]         s1_yb_lo_ff [2];
   logic [12:0]        s1_yb4_ff [2];
   logic [7:0]         s1_q100_ff [2], s1_q400_ff [2], s1_qb_ff [2];
   logic [MONTH_W-1:0] s1_mc_ff [2];
   logic [DAY_W-1:0]   s1_d_ff [2];
   logic [1:0]         s1_func_ff;
   logic [OFFSET_W-1:0] s1_off_ff;
   logic               s1_gt_ff, s1_eq_ff;

   always_comb begin
      logic [YEAR_W-1:0]  y [2];
      logic [MONTH_W-1:0] m [2];
      logic [14:0]        yb;
      y[0] = s0_y_ff;
      y[1] = s0_oy_ff;
      m[0] = s0_m_ff;
      m[1] = s0_om_ff;
      for (int i = 0; i < 2; i++) begin
         yb              = 15'(y[i]) + 15'(YEAR_BIAS);
         s1_y1_in[i]     = yb - 15'd1;
         s1_yb_lo_in[i]  = yb[1:0];
         s1_yb4_in[i]    = yb[14:2];
         s1_q100_in[i]   = div25(s1_y1_in[i][14:2]);
         s1_q400_in[i]   = div25({2'b00, s1_y1_in[i][14:4]});
         s1_qb_in[i]     = div25(yb[14:2]);
         // clamp the month into 1..12
         if (m[i] == '0)
            s1_mc_in[i] = 4'd1;
         else if (m[i] > 4'd12)
            s1_mc_in[i] = 4'd12;
         else
            s1_mc_in[i] = m[i];
      end
      // order on raw fields: year, then month, then day
      s1_gt_in = {s0_y_ff, s0_m_ff, s0_d_ff} > {s0_oy_ff, s0_om_ff, s0_od_ff};
      s1_eq_in = {s0_y_ff, s0_m_ff, s0_d_ff} == {s0_oy_ff, s0_om_ff, s0_od_ff};
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         for (int i = 0; i < 2; i++) begin
            s1_y1_ff[i]    <= s1_y1_in[i];
            s1_yb_lo_ff[i] <= s1_yb_lo_in[i];
            s1_yb4_ff[i]   <= s1_yb4_in[i];
            s1_q100_ff[i]  <= s1_q100_in[i];
            s1_q400_ff[i]  <= s1_q400_in[i];
            s1_qb_ff[i]    <= s1_qb_in[i];
            s1_mc_ff[i]    <= s1_mc_in[i];
         end
         s1_d_ff[0] <= s0_d_ff;
         s1_d_ff[1] <= s0_od_ff;
         s1_func_ff <= s0_func_ff;
         s1_off_ff  <= s0_off_ff;
         s1_gt_ff   <= s1_gt_in;
         s1_eq_ff   <= s1_eq_in;
      end
   end

   // ---------------- stage 2: serial day counts ----------------
   logic [SERIAL_W-1:0] s2_serial_in [2];
   logic [SERIAL_W-1:0] s2_serial_ff [2];
   logic [1:0]          s2_func_ff;
   logic [OFFSET_W-1:0] s2_off_ff;
   logic                s2_gt_ff, s2_eq_ff;

   always_comb begin
      logic [12:0] rb;
      logic        leap;
      logic [23:0] s;
      for (int i = 0; i < 2; i++) begin
         rb   = s1_yb4_ff[i] - 13'(s1_qb_ff[i]) * 13'd25;
         leap = (s1_yb_lo_ff[i] == 2'b00) && ((rb != '0) || (s1_qb_ff[i][1:0] == 2'b00));
         s    = 24'(s1_y1_ff[i]) * 24'(DAYS_1Y)
              + 24'(s1_y1_ff[i][14:2])
              + 24'(s1_q400_ff[i])
              + 24'(month_start(s1_mc_ff[i]))
              + 24'(leap && (s1_mc_ff[i] > 4'd2))
              + 24'(s1_d_ff[i])
              - 24'(s1_q100_ff[i])
              - 24'd1;
         s2_serial_in[i] = s[SERIAL_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s2_serial_ff[0] <= s2_serial_in[0];
         s2_serial_ff[1] <= s2_serial_in[1];
         s2_func_ff      <= s1_func_ff;
         s2_off_ff       <= s1_off_ff;
         s2_gt_ff        <= s1_gt_ff;
         s2_eq_ff        <= s1_eq_ff;
      end
   end

   // ---------------- stage 3: shift and difference ----------------
   logic [SERIAL_W-1:0]      s3_shift_in, s3_shift_ff;
   logic signed [DIFF_W-1:0] s3_diff_in, s3_diff_ff;
   logic [1:0]               s3_func_ff;
   logic                     s3_gt_ff, s3_eq_ff;

   always_comb begin
      logic [23:0]        off_x, sh;
      logic signed [23:0] d;
      off_x = {{(24-OFFSET_W){s2_off_ff[OFFSET_W-1]}}, s2_off_ff};
      if (s2_func_ff == FUNC_SUB)
         sh = 24'(s2_serial_ff[0]) - off_x;
      else
         sh = 24'(s2_serial_ff[0]) + off_x;
      s3_shift_in = sh[SERIAL_W-1:0];
      d = $signed({1'b0, s2_serial_ff[0]}) - $signed({1'b0, s2_serial_ff[1]});
      // saturate into the result field
      if (d > 24'sd4194303)
         s3_diff_in = DIFF_W'(DIFF_LIMIT);
      else if (d < -24'sd4194303)
         s3_diff_in = -DIFF_W'(DIFF_LIMIT);
      else
         s3_diff_in = d[DIFF_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s3_shift_ff <= s3_shift_in;
         s3_diff_ff  <= s3_diff_in;
         s3_func_ff  <= s2_func_ff;
         s3_gt_ff    <= s2_gt_ff;
         s3_eq_ff    <= s2_eq_ff;
      end
   end

   // ---------------- stage 4: 400-year cycles ----------------
   logic [5:0]               s4_n400_ff;
   logic [SERIAL_W-1:0]      s4_shift_ff;
   logic signed [DIFF_W-1:0] s4_diff_ff;
   logic [1:0]               s4_func_ff;
   logic                     s4_gt_ff, s4_eq_ff;

   always_ff @(posedge clock) begin
      if (advance) begin
         s4_n400_ff  <= div_400y(s3_shift_ff);
         s4_shift_ff <= s3_shift_ff;
         s4_diff_ff  <= s3_diff_ff;
         s4_func_ff  <= s3_func_ff;
         s4_gt_ff    <= s3_gt_ff;
         s4_eq_ff    <= s3_eq_ff;
      end
   end

   // ---------------- stage 5: centuries, capped at three ----------------
   logic [1:0]               s5_n100_in, s5_n100_ff;
   logic [15:0]              s5_rem_in, s5_rem_ff;
   logic [5:0]               s5_n400_ff;
   logic signed [DIFF_W-1:0] s5_diff_ff;
   logic [1:0]               s5_func_ff;
   logic                     s5_gt_ff, s5_eq_ff;

   always_comb begin
      logic [17:0] r;
      logic [17:0] sub;
      r = 18'(s4_shift_ff - SERIAL_W'(s4_n400_ff) * SERIAL_W'(DAYS_400Y));
      if (r >= 18'(3 * DAYS_100Y)) begin
         s5_n100_in = 2'd3;
         sub        = 18'(3 * DAYS_100Y);
      end else if (r >= 18'(2 * DAYS_100Y)) begin
         s5_n100_in = 2'd2;
         sub        = 18'(2 * DAYS_100Y);
      end else if (r >= 18'(DAYS_100Y)) begin
         s5_n100_in = 2'd1;
         sub        = 18'(DAYS_100Y);
      end else begin
         s5_n100_in = 2'd0;
         sub        = '0;
      end
      s5_rem_in = 16'(r - sub);
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s5_n100_ff <= s5_n100_in;
         s5_rem_ff  <= s5_rem_in;
         s5_n400_ff <= s4_n400_ff;
         s5_diff_ff <= s4_diff_ff;
         s5_func_ff <= s4_func_ff;
         s5_gt_ff   <= s4_gt_ff;
         s5_eq_ff   <= s4_eq_ff;
      end
   end

   // ---------------- stage 6: 4-year cycles ----------------
   logic [4:0]               s6_n4_ff;
   logic [15:0]              s6_rem_ff;
   logic [1:0]               s6_n100_ff;
   logic [5:0]               s6_n400_ff;
   logic signed [DIFF_W-1:0] s6_diff_ff;
   logic [1:0]               s6_func_ff;
   logic                     s6_gt_ff, s6_eq_ff;

   always_ff @(posedge clock) begin
      if (advance) begin
         s6_n4_ff   <= div_4y(s5_rem_ff);
         s6_rem_ff  <= s5_rem_ff;
         s6_n100_ff <= s5_n100_ff;
         s6_n400_ff <= s5_n400_ff;
         s6_diff_ff <= s5_diff_ff;
         s6_func_ff <= s5_func_ff;
         s6_gt_ff   <= s5_gt_ff;
         s6_eq_ff   <= s5_eq_ff;
      end
   end

   // ---------------- stage 7: single years and biased year ----------------
   logic [8:0]               s7_doy_in, s7_doy_ff;
   logic [14:0]              s7_yy_in, s7_yy_ff;
   logic                     s7_leap_in, s7_leap_ff;
   logic signed [DIFF_W-1:0] s7_diff_ff;
   logic [1:0]               s7_func_ff;
   logic                     s7_gt_ff, s7_eq_ff;

   always_comb begin
      logic [10:0] r;
      logic [1:0]  n1;
      logic [10:0] sub;
      r = 11'(s6_rem_ff - 16'(s6_n4_ff) * 16'(DAYS_4Y));
      if (r >= 11'(3 * DAYS_1Y)) begin
         n1  = 2'd3;
         sub = 11'(3 * DAYS_1Y);
      end else if (r >= 11'(2 * DAYS_1Y)) begin
         n1  = 2'd2;
         sub = 11'(2 * DAYS_1Y);
      end else if (r >= 11'(DAYS_1Y)) begin
         n1  = 2'd1;
         sub = 11'(DAYS_1Y);
      end else begin
         n1  = 2'd0;
         sub = '0;
      end
      s7_doy_in  = 9'(r - sub);
      s7_yy_in   = 15'(s6_n400_ff) * 15'd400 + 15'(s6_n100_ff) * 15'd100
                 + 15'(s6_n4_ff) * 15'd4 + 15'(n1) + 15'd1;
      // last year of a 4-year cycle is leap, but for the century year of a short cycle
      s7_leap_in = (n1 == 2'd3) && ((s6_n4_ff != 5'd24) || (s6_n100_ff == 2'd3));
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s7_doy_ff  <= s7_doy_in;
         s7_yy_ff   <= s7_yy_in;
         s7_leap_ff <= s7_leap_in;
         s7_diff_ff <= s6_diff_ff;
         s7_func_ff <= s6_func_ff;
         s7_gt_ff   <= s6_gt_ff;
         s7_eq_ff   <= s6_eq_ff;
      end
   end

   // ---------------- stage 8: month, day and result selection ----------------
   logic [YEAR_W-1:0]        rsp_year_in, rsp_year_ff;
   logic [MONTH_W-1:0]       rsp_month_in, rsp_month_ff;
   logic [DAY_W-1:0]         rsp_day_in, rsp_day_ff;
   logic signed [DIFF_W-1:0] rsp_diff_in, rsp_diff_ff;
   logic                     rsp_gt_in, rsp_gt_ff;
   logic                     rsp_eq_in, rsp_eq_ff;
   logic                     rsp_lt_in, rsp_lt_ff;
   logic                     rsp_ovf_in, rsp_ovf_ff;

   always_comb begin
      logic [MONTH_W-1:0] mm;
      logic [8:0]         st, mst;
      logic               ovf;
      mm  = 4'd1;
      mst = '0;
      for (int k = 2; k <= 12; k++) begin
         st = month_start(MONTH_W'(k)) + 9'((s7_leap_ff && (k > 2)) ? 1 : 0);
         if (s7_doy_ff >= st) begin
            mm  = MONTH_W'(k);
            mst = st;
         end
      end
      ovf = (s7_yy_ff < 15'(YEAR_MIN + YEAR_BIAS)) || (s7_yy_ff > 15'(YEAR_MAX + YEAR_BIAS));

      rsp_year_in  = '0;
      rsp_month_in = '0;
      rsp_day_in   = '0;
      rsp_diff_in  = '0;
      rsp_gt_in    = 1'b0;
      rsp_eq_in    = 1'b0;
      rsp_lt_in    = 1'b0;
      rsp_ovf_in   = 1'b0;
      case (s7_func_ff)
         FUNC_ADD, FUNC_SUB: begin
            if (ovf) begin
               rsp_ovf_in = 1'b1;
            end else begin
               rsp_year_in  = YEAR_W'(s7_yy_ff - 15'(YEAR_BIAS));
               rsp_month_in = mm;
               rsp_day_in   = DAY_W'(s7_doy_ff - mst + 9'd1);
            end
         end
         FUNC_DIFF: begin
            rsp_diff_in = s7_diff_ff;
         end
         FUNC_CMP: begin
            rsp_gt_in = s7_gt_ff;
            rsp_eq_in = s7_eq_ff;
            rsp_lt_in = !s7_gt_ff && !s7_eq_ff;
         end
         default: begin
            rsp_ovf_in = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_year_ff  <= rsp_year_in;
         rsp_month_ff <= rsp_month_in;
         rsp_day_ff   <= rsp_day_in;
         rsp_diff_ff  <= rsp_diff_in;
         rsp_gt_ff    <= rsp_gt_in;
         rsp_eq_ff    <= rsp_eq_in;
         rsp_lt_ff    <= rsp_lt_in;
         rsp_ovf_ff   <= rsp_ovf_in;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_result_year    = rsp_year_ff;
   assign rsp_result_month   = rsp_month_ff;
   assign rsp_result_day     = rsp_day_ff;
   assign rsp_day_difference = rsp_diff_ff;
   assign rsp_is_greater     = rsp_gt_ff;
   assign rsp_is_equal       = rsp_eq_ff;
   assign rsp_is_less        = rsp_lt_ff;
   assign rsp_overflow       = rsp_ovf_ff;

endmodule

// File: rtl/cda_checker.sv
// ----------------------------------------------------------------------------
// cda_checker
// Port-level checks on the date arithmetic block, bound to the top level.
// ----------------------------------------------------------------------------
module cda_checker (
   input logic                           clock,
   input logic                           reset,
   input logic                           req_ready,
   input logic                           rsp_valid,
   input logic                           rsp_ready,
   input logic [cda_pkg::YEAR_W-1:0]     rsp_result_year,
   input logic [cda_pkg::MONTH_W-1:0]    rsp_result_month,
   input logic [cda_pkg::DAY_W-1:0]      rsp_result_day,
   input logic                           rsp_is_greater,
   input logic                           rsp_is_equal,
   input logic                           rsp_is_less,
   input logic                           rsp_overflow
);
   import cda_pkg::*;

   // hold a stalled item unchanged
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_result_year)
         && $stable(rsp_result_month) && $stable(rsp_result_day))
      else $error("stalled result item changed");

   a_ready: assert property (@(posedge clock) disable iff (reset)
      req_ready == (!rsp_valid || rsp_ready))
      else $error("req_ready does not follow the output slot");

   a_order: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $onehot0({rsp_is_greater, rsp_is_equal, rsp_is_less}))
      else $error("more than one order flag set");

   a_ovf: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_overflow |-> (rsp_result_year == '0) && (rsp_result_month == '0)
         && (rsp_result_day == '0))
      else $error("overflowed item carries a date");

endmodule

bind calendar_date_arithmetic cda_checker u_cda_checker (.*);

// File: verif/calendar_date_arithmetic_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// calendar_date_arithmetic_checker
// Watches both channels of the date arithmetic block. It predicts each result
// from the accepted request and compares it, field by field, in order.
// ----------------------------------------------------------------------------
module calendar_date_arithmetic_checker (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   input  logic                                 req_ready,
   input  logic [1:0]                           req_func,
   input  logic [cda_pkg::YEAR_W-1:0]           req_year,
   input  logic [cda_pkg::MONTH_W-1:0]          req_month,
   input  logic [cda_pkg::DAY_W-1:0]            req_day,
   input  logic signed [cda_pkg::OFFSET_W-1:0]  req_offset_days,
   input  logic [cda_pkg::YEAR_W-1:0]           req_other_year,
   input  logic [cda_pkg::MONTH_W-1:0]          req_other_month,
   input  logic [cda_pkg::DAY_W-1:0]            req_other_day,
   input  logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   input  logic [cda_pkg::YEAR_W-1:0]           rsp_result_year,
   input  logic [cda_pkg::MONTH_W-1:0]          rsp_result_month,
   input  logic [cda_pkg::DAY_W-1:0]            rsp_result_day,
   input  logic signed [cda_pkg::DIFF_W-1:0]    rsp_day_difference,
   input  logic                                 rsp_is_greater,
   input  logic                                 rsp_is_equal,
   input  logic                                 rsp_is_less,
   input  logic                                 rsp_overflow,
   output int                                   fail_count,
   output int                                   pending_count
);
   import cda_pkg::*;

   typedef struct packed {
      logic [YEAR_W-1:0]        year;
      logic [MONTH_W-1:0]       month;
      logic [DAY_W-1:0]         day;
      logic signed [DIFF_W-1:0] diff;
      logic                     gt;
      logic                     eq;
      logic                     lt;
      logic                     ovf;
   } date_result_type;

   localparam longint MONTH_DAYS [13] = '{0,31,28,31,30,31,30,31,31,30,31,30,31};

   date_result_type expected_dates[$];

   function automatic bit is_leap(input longint y);
      return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
   endfunction

   function automatic longint month_days(input longint y, input longint m);
      if (m == 2 && is_leap(y)) return 29;
      return MONTH_DAYS[m];
   endfunction

   // Biased serial count; month is clamped to 1..12, day counted as given
   function automatic longint date_serial(input longint y_raw, input longint m_raw,
                                          input longint d_raw);
      longint y, m, y1, s;
      y = y_raw + YEAR_BIAS;
      m = m_raw;
      if (m < 1) m = 1;
      if (m > 12) m = 12;
      y1 = y - 1;
      s = y1 * 365 + y1 / 4 - y1 / 100 + y1 / 400;
      for (longint k = 1; k < m; k++) s += month_days(y, k);
      return s + d_raw - 1;
   endfunction

   function automatic date_result_type predict_result(
         input logic [1:0] f, input longint y, input longint m, input longint d,
         input longint off, input longint oy, input longint om, input longint od);
      date_result_type r;
      longint s, n400, n100, n4, n1, yy, mm, diff;
      r = '0;
      if (f == FUNC_ADD || f == FUNC_SUB) begin
         s = date_serial(y, m, d);
         s = (f == FUNC_ADD) ? s + off : s - off;
         n400 = s / DAYS_400Y;
         s = s % DAYS_400Y;
         n100 = s / DAYS_100Y;
         if (n100 > 3) n100 = 3;
         s -= n100 * DAYS_100Y;
         n4 = s / DAYS_4Y;
         s -= n4 * DAYS_4Y;
         n1 = s / 365;
         if (n1 > 3) n1 = 3;
         s -= n1 * 365;
         yy = n400 * 400 + n100 * 100 + n4 * 4 + n1 + 1;
         mm = 1;
         while (mm < 12 && s >= month_days(yy, mm)) begin
            s -= month_days(yy, mm);
            mm++;
         end
         yy -= YEAR_BIAS;
         if (yy < YEAR_MIN || yy > YEAR_MAX) begin
            r.ovf = 1'b1;
         end else begin
            r.year  = yy[YEAR_W-1:0];
            r.month = mm[MONTH_W-1:0];
            r.day   = DAY_W'(s + 1);
         end
      end else if (f == FUNC_DIFF) begin
         diff = date_serial(y, m, d) - date_serial(oy, om, od);
         if (diff > DIFF_LIMIT) diff = DIFF_LIMIT;
         if (diff < -DIFF_LIMIT) diff = -DIFF_LIMIT;
         r.diff = diff[DIFF_W-1:0];
      end else begin
         // order on raw fields: year, then month, then day
         r.eq = (y == oy) && (m == om) && (d == od);
         if (y != oy)      r.gt = y > oy;
         else if (m != om) r.gt = m > om;
         else              r.gt = d > od;
         r.lt = !r.gt && !r.eq;
      end
      return r;
   endfunction

   always @(posedge clock) begin
      date_result_type exp_r, got_r;
      if (reset) begin
         fail_count    <= 0;
         pending_count <= 0;
         expected_dates.delete();
      end else begin
         if (req_valid && req_ready)
            expected_dates.push_back(predict_result(req_func, req_year, req_month,
               req_day, longint'(req_offset_days), req_other_year, req_other_month,
               req_other_day));
         if (rsp_valid && rsp_ready) begin
            got_r = '{rsp_result_year, rsp_result_month, rsp_result_day,
                      rsp_day_difference, rsp_is_greater, rsp_is_equal,
                      rsp_is_less, rsp_overflow};
            if (expected_dates.size() == 0) begin
               if (fail_count < 10)
                  $display("%0t: result with nothing outstanding: %p", $realtime, got_r);
               fail_count <= fail_count + 1;
            end else begin
               exp_r = expected_dates.pop_front();
               if (got_r !== exp_r) begin
                  if (fail_count < 10)
                     $display("%0t: mismatch\n  exp %p\n  got %p", $realtime, exp_r, got_r);
                  fail_count <= fail_count + 1;
               end
            end
         end
         pending_count <= expected_dates.size();
      end
   end

endmodule

// File: verif/calendar_date_arithmetic_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// calendar_date_arithmetic_test
// Drives date shift, difference and compare requests into the block under
// three idling regimes and one long output stall; the checker judges results.
// ----------------------------------------------------------------------------
module calendar_date_arithmetic_test;
   import cda_pkg::*;

   localparam int STALL_LIMIT = 20000;
   localparam int RANDOM_ITEMS = 750;

   logic                        clock;
   logic                        reset;
   logic                        req_valid;
   logic                        req_ready;
   logic [1:0]                  req_func;
   logic [YEAR_W-1:0]           req_year;
   logic [MONTH_W-1:0]          req_month;
   logic [DAY_W-1:0]            req_day;
   logic signed [OFFSET_W-1:0]  req_offset_days;
   logic [YEAR_W-1:0]           req_other_year;
   logic [MONTH_W-1:0]          req_other_month;
   logic [DAY_W-1:0]            req_other_day;
   logic                        rsp_valid;
   logic                        rsp_ready;
   logic [YEAR_W-1:0]           rsp_result_year;
   logic [MONTH_W-1:0]          rsp_result_month;
   logic [DAY_W-1:0]            rsp_result_day;
   logic signed [DIFF_W-1:0]    rsp_day_difference;
   logic                        rsp_is_greater;
   logic                        rsp_is_equal;
   logic                        rsp_is_less;
   logic                        rsp_overflow;
   int                          fail_count;
   int                          pending_count;

   // idling percentages and the long output hold-off, set by the main sequence
   int send_idle_pct;
   int recv_idle_pct;
   int hold_request;
   int hold_left;
   int idle_cycles;
   int op_count [4];

   calendar_date_arithmetic dut (.*);
   calendar_date_arithmetic_checker checker_i (.*);

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // Receiver: random back-pressure, or a counted hold-off when one is asked
   always @(posedge clock) begin
      if (hold_request > 0 && hold_left == 0) begin
         hold_left    = hold_request;
         hold_request = 0;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // Watchdog: count cycles in which neither channel moves an item
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   // Offer one item and hold it until accepted. Entered just after an edge,
   // so valid is only lowered here in a step where it is not raised again.
   task automatic send_date_req(input func_type f, input int y, input int m,
                                input int d, input int off, input int oy,
                                input int om, input int od);
      if ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < send_idle_pct);
      end
      req_valid       <= 1'b1;
      req_func        <= f;
      req_year        <= YEAR_W'(y);
      req_month       <= MONTH_W'(m);
      req_day         <= DAY_W'(d);
      req_offset_days <= OFFSET_W'(off);
      req_other_year  <= YEAR_W'(oy);
      req_other_month <= MONTH_W'(om);
      req_other_day   <= DAY_W'(od);
      op_count[f]++;
      do @(posedge clock); while (!req_ready);
   endtask

   // Random request: mostly sane dates, one in ten with raw field widths
   task automatic send_random_req();
      func_type f;
      bit raw;
      f   = func_type'($urandom_range(3));
      raw = ($urandom_range(9) == 0);
      if (raw)
         send_date_req(f, $urandom_range(16383), $urandom_range(15), $urandom_range(31),
                       $urandom_range(131071) - 65536, $urandom_range(16383),
                       $urandom_range(15), $urandom_range(31));
      else if (f == FUNC_CMP && $urandom_range(2) == 0)
         // near-equal dates so that every order flag shows up
         send_date_req(f, 2000, $urandom_range(1, 2), $urandom_range(1, 2), 0,
                       2000, $urandom_range(1, 2), $urandom_range(1, 2));
      else
         send_date_req(f, $urandom_range(1, 9999), $urandom_range(1, 12),
                       $urandom_range(1, 28), $urandom_range(131071) - 65536,
                       $urandom_range(1, 9999), $urandom_range(1, 12),
                       $urandom_range(1, 28));
   endtask

   initial begin
      send_idle_pct   = 28;
      recv_idle_pct   = 84;
      hold_request    = 0;
      op_count        = '{default: 0};
      reset           <= 1'b1;
      req_valid       <= 1'b0;
      req_func        <= FUNC_ADD;
      req_year        <= '0;
      req_month       <= '0;
      req_day         <= '0;
      req_offset_days <= '0;
      req_other_year  <= '0;
      req_other_month <= '0;
      req_other_day   <= '0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: range ends, leap days, year crossings, overflow, odd fields
      send_date_req(FUNC_ADD, 2024, 2, 28, 1, 1, 1, 1);
      send_date_req(FUNC_ADD, 2023, 2, 28, 1, 1, 1, 1);
      send_date_req(FUNC_SUB, 2024, 1, 1, 1, 1, 1, 1);       // back across December
      send_date_req(FUNC_SUB, 2001, 1, 15, 30, 1, 1, 1);
      send_date_req(FUNC_ADD, 1900, 2, 28, 1, 1, 1, 1);
      send_date_req(FUNC_ADD, 2000, 2, 28, 1, 1, 1, 1);
      send_date_req(FUNC_ADD, 9999, 12, 31, 1, 1, 1, 1);     // past the top year
      send_date_req(FUNC_SUB, 1, 1, 1, 1, 1, 1, 1);          // below year one
      send_date_req(FUNC_ADD, 1, 1, 1, 65535, 1, 1, 1);
      send_date_req(FUNC_ADD, 9999, 12, 31, -65536, 1, 1, 1);
      send_date_req(FUNC_SUB, 5000, 6, 15, -65536, 1, 1, 1);
      send_date_req(FUNC_ADD, 2020, 0, 0, 0, 1, 1, 1);       // month and day zero
      send_date_req(FUNC_ADD, 2020, 15, 31, 0, 1, 1, 1);     // month above twelve
      send_date_req(FUNC_ADD, 2021, 2, 31, 0, 1, 1, 1);      // day past month end
      send_date_req(FUNC_ADD, 0, 6, 1, 200000 % 65536, 1, 1, 1);
      send_date_req(FUNC_SUB, 16383, 15, 31, 0, 1, 1, 1);
      send_date_req(FUNC_DIFF, 9999, 12, 31, 0, 1, 1, 1);
      send_date_req(FUNC_DIFF, 1, 1, 1, 0, 9999, 12, 31);
      send_date_req(FUNC_DIFF, 16383, 15, 31, 0, 0, 0, 0);   // saturates high
      send_date_req(FUNC_DIFF, 0, 0, 0, 0, 16383, 15, 31);   // saturates low
      send_date_req(FUNC_DIFF, 2024, 3, 1, 0, 2024, 2, 28);
      send_date_req(FUNC_CMP, 2024, 5, 5, 0, 2024, 5, 5);
      send_date_req(FUNC_CMP, 2024, 5, 6, 0, 2024, 5, 5);
      send_date_req(FUNC_CMP, 2024, 4, 9, 0, 2024, 5, 1);
      send_date_req(FUNC_CMP, 16383, 15, 31, 0, 0, 0, 0);

      repeat (RANDOM_ITEMS / 3) send_random_req();
      send_idle_pct = 84;
      recv_idle_pct = 28;
      repeat (RANDOM_ITEMS / 3) send_random_req();
      send_idle_pct = 0;
      recv_idle_pct = 0;
      // stall the output long enough that the pipeline fills and blocks input
      hold_request  = 300;
      repeat (RANDOM_ITEMS / 3) send_random_req();
      req_valid <= 1'b0;

      while (pending_count != 0) @(posedge clock);
      repeat (30) @(posedge clock);

      $display("Ran %0d requests (add %0d, subtract %0d, difference %0d, compare %0d)",
               op_count[0] + op_count[1] + op_count[2] + op_count[3],
               op_count[0], op_count[1], op_count[2], op_count[3]);
      $display("under sender-heavy, receiver-heavy and free-running idling plus one long stall");
      if (fail_count == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

endmodule
